[rtl/utv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utv_pkg
// Beat types, parsing state and calendar helpers shared by the UTC timestamp
// validator and its field checker.
// ----------------------------------------------------------------------------
package utv_pkg;

  localparam int unsigned PosWidth = 5;
  localparam int unsigned FieldWidth = 7;

  localparam logic [PosWidth-1:0] PosMax = 5'd31;
  // Index of the final character for each accepted form
  localparam logic [PosWidth-1:0] DateLastPos = 5'd9;
  localparam logic [PosWidth-1:0] SecondsLastPos = 5'd19;
  localparam logic [PosWidth-1:0] NanosLastPos = 5'd29;

  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;
  localparam logic [7:0] CharDash = 8'h2D;
  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharDot = 8'h2E;
  localparam logic [7:0] CharT = 8'h54;
  localparam logic [7:0] CharZ = 8'h5A;

  localparam logic [FieldWidth-1:0] MonthMax = 7'd12;
  localparam logic [FieldWidth-1:0] HourMax = 7'd23;
  localparam logic [FieldWidth-1:0] MinSecMax = 7'd59;
  localparam logic [4:0] LeapFebDays = 5'd29;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } char_beat_t;

  typedef struct packed {
    logic date_valid;
    logic seconds_valid;
    logic nanos_valid;
  } flag_beat_t;

  // Parsing state; the year is held as its upper and lower two-digit halves
  typedef struct packed {
    logic [FieldWidth-1:0] year_hi;
    logic [FieldWidth-1:0] year_lo;
    logic [FieldWidth-1:0] month;
    logic [FieldWidth-1:0] day;
    logic [FieldWidth-1:0] hour;
    logic [FieldWidth-1:0] minute;
    logic [FieldWidth-1:0] second;
    logic                  date_shape_ok;
    logic                  time_shape_ok;
    logic                  zulu_at_nineteen;
    logic                  dot_at_nineteen;
    logic                  fraction_ok;
    logic                  zulu_at_end;
  } fields_t;

  localparam fields_t FieldsReset = '{
    year_hi: '0, year_lo: '0, month: '0, day: '0,
    hour: '0, minute: '0, second: '0,
    date_shape_ok: 1'b1, time_shape_ok: 1'b1,
    zulu_at_nineteen: 1'b0, dot_at_nineteen: 1'b0,
    fraction_ok: 1'b1, zulu_at_end: 1'b0
  };

  // acc * 10 + d, kept to the field width
  function automatic logic [FieldWidth-1:0] push_digit(
    input logic [FieldWidth-1:0] acc,
    input logic [3:0]            d
  );
    logic [FieldWidth-1:0] sum;
    sum = {acc[FieldWidth-4:0], 3'b000} + {acc[FieldWidth-2:0], 1'b0}
        + {{(FieldWidth-4){1'b0}}, d};
    return sum;
  endfunction

  function automatic logic [4:0] days_in_month(
    input logic [FieldWidth-1:0] month,
    input logic                  leap
  );
    logic [4:0] days;
    unique case (month)
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: days = 5'd31;
      7'd4, 7'd6, 7'd9, 7'd11:                    days = 5'd30;
      7'd2:    days = leap ? LeapFebDays : 5'd28;
      default: days = 5'd0;
    endcase
    return days;
  endfunction

endpackage

[rtl/utv_field_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utv_field_check
// Range checks on the parsed fields and length selection for the three
// accepted timestamp forms.
// ----------------------------------------------------------------------------
module utv_field_check (
  input  utv_pkg::fields_t                  fields,
  input  logic [utv_pkg::PosWidth-1:0]      last_pos,
  output utv_pkg::flag_beat_t               flags
);
  import utv_pkg::*;

  logic       leap;
  logic       year_nonzero;
  logic [4:0] day_limit;
  logic       date_ok;
  logic       prefix_ok;

  // Year halves are two decimal digits each, so divisibility by 4, 100 and
  // 400 reduces to checks on the halves.
  assign year_nonzero = (fields.year_hi != '0) || (fields.year_lo != '0);
  assign leap = (fields.year_lo[1:0] == 2'b00) &&
                ((fields.year_lo != '0) || (fields.year_hi[1:0] == 2'b00));
  assign day_limit = days_in_month(fields.month, leap);

  assign date_ok = fields.date_shape_ok && year_nonzero &&
                   (fields.month != '0) && (fields.month <= MonthMax) &&
                   (fields.day != '0) &&
                   (fields.day <= {{(FieldWidth-5){1'b0}}, day_limit});

  assign prefix_ok = date_ok && fields.time_shape_ok &&
                     (fields.hour <= HourMax) && (fields.minute <= MinSecMax) &&
                     (fields.second <= MinSecMax);

  assign flags.date_valid    = (last_pos == DateLastPos) && date_ok;
  assign flags.seconds_valid = (last_pos == SecondsLastPos) && prefix_ok &&
                               fields.zulu_at_nineteen;
  assign flags.nanos_valid   = (last_pos == NanosLastPos) && prefix_ok &&
                               fields.dot_at_nineteen && fields.fraction_ok &&
                               fields.zulu_at_end;

endmodule

[rtl/utc_timestamp_validator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utc_timestamp_validator
// Character-serial checker for YYYY-MM-DD, YYYY-MM-DDTHH:MM:SSZ and
// YYYY-MM-DDTHH:MM:SS.nnnnnnnnnZ; one flag beat per string, on its last char.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------
//   char    | in        | char_valid / char_stall | char_data (char_beat_t)
//   flag    | out       | flag_valid / flag_stall | flag_data (flag_beat_t)
//
// One character beat per cycle while char_stall is low. A beat waits in the
// input register, where the parse logic folds it into the field state; a last
// character writes its flags into the output register, so each result is held
// in the input and then the output register. rst (synchronous) clears the parse
// state and both valid bits. A stalled flag beat only holds back a last
// character; other characters keep flowing while a result waits.
module utc_timestamp_validator (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 char_valid,
  output logic                 char_stall,
  input  utv_pkg::char_beat_t  char_data,
  output logic                 flag_valid,
  input  logic                 flag_stall,
  output utv_pkg::flag_beat_t  flag_data
);
  import utv_pkg::*;

  // Input register
  logic                s1_valid;
  logic [7:0]          s1_char;
  logic                s1_last;

  // Parse state
  logic [PosWidth-1:0] position;
  fields_t             fields;
  fields_t             fields_next;

  logic                advance;
  logic                accept;
  logic                is_digit;
  logic [3:0]          digit;
  flag_beat_t          flags;

  // A last character needs room in the output register; others never wait.
  assign advance    = s1_valid && (!s1_last || !flag_valid || !flag_stall);
  assign char_stall = s1_valid && !advance;
  assign accept     = char_valid && !char_stall;

  assign is_digit = (s1_char >= CharZero) && (s1_char <= CharNine);
  assign digit    = s1_char[3:0];

  // Fold the current character into the field state by its position.
  // Non-digits in digit slots clear the shape or fraction flag, leave the field.
  always_comb begin
    fields_next = fields;
    unique case (position)
      5'd0, 5'd1: begin
        if (is_digit) fields_next.year_hi = push_digit(fields.year_hi, digit);
        else fields_next.date_shape_ok = 1'b0;
      end
      5'd2, 5'd3: begin
        if (is_digit) fields_next.year_lo = push_digit(fields.year_lo, digit);
        else fields_next.date_shape_ok = 1'b0;
      end
      5'd4, 5'd7: begin
        if (s1_char != CharDash) fields_next.date_shape_ok = 1'b0;
      end
      5'd5, 5'd6: begin
        if (is_digit) fields_next.month = push_digit(fields.month, digit);
        else fields_next.date_shape_ok = 1'b0;
      end
      5'd8, 5'd9: begin
        if (is_digit) fields_next.day = push_digit(fields.day, digit);
        else fields_next.date_shape_ok = 1'b0;
      end
      5'd10: begin
        if (s1_char != CharT) fields_next.time_shape_ok = 1'b0;
      end
      5'd11, 5'd12: begin
        if (is_digit) fields_next.hour = push_digit(fields.hour, digit);
        else fields_next.time_shape_ok = 1'b0;
      end
      5'd13, 5'd16: begin
        if (s1_char != CharColon) fields_next.time_shape_ok = 1'b0;
      end
      5'd14, 5'd15: begin
        if (is_digit) fields_next.minute = push_digit(fields.minute, digit);
        else fields_next.time_shape_ok = 1'b0;
      end
      5'd17, 5'd18: begin
        if (is_digit) fields_next.second = push_digit(fields.second, digit);
        else fields_next.time_shape_ok = 1'b0;
      end
      5'd19: begin
        fields_next.zulu_at_nineteen = (s1_char == CharZ);
        fields_next.dot_at_nineteen  = (s1_char == CharDot);
      end
      5'd20, 5'd21, 5'd22, 5'd23, 5'd24, 5'd25, 5'd26, 5'd27, 5'd28: begin
        if (!is_digit) fields_next.fraction_ok = 1'b0;
      end
      5'd29: begin
        fields_next.zulu_at_end = (s1_char == CharZ);
      end
      default: begin
        // past the longest form: touch nothing
      end
    endcase
  end

  // Checks run on the state that includes the last character itself.
  utv_field_check u_check (
    .fields   (fields_next),
    .last_pos (position),
    .flags    (flags)
  );

  // Input register: load on accept, drop once the beat has been folded in
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_char <= char_data.char_code;
      s1_last <= char_data.last;
    end
  end

  // Parse state: advance per character, return to reset after a last one
  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      fields   <= FieldsReset;
    end else if (advance) begin
      if (s1_last) begin
        position <= '0;
        fields   <= FieldsReset;
      end else begin
        if (position != PosMax) position <= position + 1'b1;
        fields <= fields_next;
      end
    end
  end

  // Output register: hold a result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      flag_valid <= 1'b0;
    end else if (advance && s1_last) begin
      flag_valid <= 1'b1;
    end else if (!flag_stall) begin
      flag_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_last) begin
      flag_data <= flags;
    end
  end

endmodule
